// File: rtl/rcd_pkg.sv
package rcd_pkg;

	// Fixed field widths of the channels
	localparam int PRICE_W   = 16;
	localparam int PIECE_W   = 6;
	localparam int REV_OUT_W = 21;

endpackage

// File: rtl/rcd_if.sv
interface rcd_price_if;
	import rcd_pkg::*;

	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] price;
	logic               last_price;

	modport source (output valid, price, last_price, input ready);
	modport sink   (input valid, price, last_price, output ready);
endinterface

interface rcd_piece_if;
	import rcd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [PIECE_W-1:0]   piece_length;
	logic [REV_OUT_W-1:0] best_revenue;
	logic                 last_piece;

	modport source (output valid, piece_length, best_revenue, last_piece, input ready);
	modport sink   (input valid, piece_length, best_revenue, last_piece, output ready);
endinterface

// File: rtl/rod_cutting_dp.sv
// Rod cutting solver. Prices for piece lengths 1, 2, 3, ... arrive one beat each on
// "prices"; the beat flagged last_price closes the load and its position (capped at
// MAX_LEN, later prices are dropped) is the rod length n. Loading accepts one beat per
// cycle. The block then fills a revenue/first-cut table for every length 1..n on one
// shared compare-add unit fed by two single-read memories with registered reads:
// length L issues one read pair per cut 1..L and then a write-back step; during the
// solve no price is accepted. It then walks the first-cut table from n down, emitting
// one beat per piece on "pieces" (a table read, then an output step that waits for a
// free output register), each with the total best revenue; last_piece flags the final
// piece. On equal revenue the smaller first piece wins. A fresh load may start as soon
// as the final piece sits in the output register.
module rod_cutting_dp #(
	parameter int MAX_LEN    = 32,
	parameter int PRICE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	rcd_price_if.sink    prices,
	rcd_piece_if.source  pieces
);
	import rcd_pkg::*;

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int PA_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int REV_W = PRICE_BITS + CNT_W;

	localparam logic [2:0] ST_LOAD     = 3'd0;
	localparam logic [2:0] ST_SOLVE    = 3'd1;
	localparam logic [2:0] ST_WB       = 3'd2;
	localparam logic [2:0] ST_EMIT_RD  = 3'd3;
	localparam logic [2:0] ST_EMIT_DAT = 3'd4;

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

	// Memories: prices by length-1, and per-length best revenue with its first cut
	logic [PRICE_BITS-1:0] price_mem [MAX_LEN];
	logic [REV_W-1:0]      rev_mem   [MAX_LEN+1];
	logic [CNT_W-1:0]      cut_mem   [MAX_LEN+1];

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      cut_q;
	logic [CNT_W-1:0]      rem_q;
	logic [REV_W-1:0]      best_q;
	logic [CNT_W-1:0]      bcut_q;
	logic [REV_W-1:0]      total_q;

	logic [PRICE_BITS-1:0] price_rd_q;
	logic [REV_W-1:0]      rev_rd_q;
	logic [CNT_W-1:0]      cut_rd_q;

	// Compare stage, in the cycle after the read issue
	logic                  valid_s1;
	logic                  first_s1;
	logic                  last_s1;
	logic                  zero_s1;
	logic [CNT_W-1:0]      cut_s1;

	logic                  out_valid_q;
	logic [PIECE_W-1:0]    out_piece_q;
	logic [REV_OUT_W-1:0]  out_rev_q;
	logic                  out_last_q;

	logic                  in_fire;
	logic                  out_free;
	logic                  store_en;
	logic [CNT_W-1:0]      n_next;
	logic                  tbl_rd_en;
	logic [CNT_W-1:0]      tbl_rd_addr;
	logic [REV_W-1:0]      cand;
	logic                  take;
	logic [REV_W-1:0]      new_best;
	logic [CNT_W-1:0]      new_cut;
	logic                  wb_en;
	logic [CNT_W-1:0]      piece;
	logic [CNT_W-1:0]      rem_next;
	logic                  emit_go;

	assign prices.ready = (state_q == ST_LOAD);
	assign in_fire      = prices.valid && prices.ready;
	assign out_free     = !out_valid_q || pieces.ready;

	// Drop prices once the store is full; the count saturates
	assign store_en = in_fire && (count_q < CNT_MAX);
	assign n_next   = store_en ? count_q + CNT_ONE : count_q;

	assign tbl_rd_en   = (state_q == ST_SOLVE) || (state_q == ST_EMIT_RD);
	assign tbl_rd_addr = (state_q == ST_SOLVE) ? len_q - cut_q : rem_q;

	// Candidate: price of first piece plus best revenue of the remainder (zero rod is free)
	assign cand     = REV_W'(price_rd_q) + (zero_s1 ? '0 : rev_rd_q);
	assign take     = first_s1 || (cand > best_q);
	assign new_best = take ? cand : best_q;
	assign new_cut  = take ? cut_s1 : bcut_q;
	assign wb_en    = valid_s1 && last_s1;

	// Next piece of the plan; fall back to the whole remainder on a bad entry
	assign piece    = (cut_rd_q == '0 || cut_rd_q > rem_q) ? rem_q : cut_rd_q;
	assign rem_next = rem_q - piece;
	assign emit_go  = (state_q == ST_EMIT_DAT) && out_free;

	always_ff @(posedge clk) begin
		if (store_en) begin
			price_mem[count_q[PA_W-1:0]] <= PRICE_BITS'(prices.price);
		end
		if (state_q == ST_SOLVE) begin
			price_rd_q <= price_mem[PA_W'(cut_q - CNT_ONE)];
		end
	end

	always_ff @(posedge clk) begin
		if (wb_en) begin
			rev_mem[len_q] <= new_best;
			cut_mem[len_q] <= new_cut;
		end
		if (tbl_rd_en) begin
			rev_rd_q <= rev_mem[tbl_rd_addr];
			cut_rd_q <= cut_mem[tbl_rd_addr];
		end
	end

	// Running best within one length; hold the total of the last length written
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			best_q <= new_best;
			bcut_q <= new_cut;
		end
		if (wb_en) begin
			total_q <= new_best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			n_q      <= '0;
			len_q    <= '0;
			cut_q    <= '0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			zero_s1  <= 1'b0;
			cut_s1   <= '0;
		end else begin
			valid_s1 <= (state_q == ST_SOLVE);
			first_s1 <= (cut_q == CNT_ONE);
			last_s1  <= (cut_q == len_q);
			zero_s1  <= (cut_q == len_q);
			cut_s1   <= cut_q;
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (prices.last_price) begin
							n_q     <= n_next;
							count_q <= '0;
							len_q   <= CNT_ONE;
							cut_q   <= CNT_ONE;
							state_q <= ST_SOLVE;
						end else begin
							count_q <= n_next;
						end
					end
				end
				ST_SOLVE: begin
					// Issue one read pair per cut; bubble for write-back after the last
					if (cut_q == len_q) begin
						state_q <= ST_WB;
					end else begin
						cut_q <= cut_q + CNT_ONE;
					end
				end
				ST_WB: begin
					if (len_q == n_q) begin
						rem_q   <= n_q;
						state_q <= ST_EMIT_RD;
					end else begin
						len_q   <= len_q + CNT_ONE;
						cut_q   <= CNT_ONE;
						state_q <= ST_SOLVE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_DAT;
				end
				ST_EMIT_DAT: begin
					if (emit_go) begin
						rem_q   <= rem_next;
						state_q <= (rem_next == '0) ? ST_LOAD : ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output register: parts the solver from a stalled sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (pieces.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_piece_q <= PIECE_W'(piece);
			out_rev_q   <= REV_OUT_W'(total_q);
			out_last_q  <= (rem_next == '0);
		end
	end

	assign pieces.valid        = out_valid_q;
	assign pieces.piece_length = out_piece_q;
	assign pieces.best_revenue = out_rev_q;
	assign pieces.last_piece   = out_last_q;

endmodule
